// ===== hdl/cfwp_pkg.sv =====
package cfwp_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OFF_W  = 4;
  localparam int unsigned REQ_W  = 2;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;

endpackage

// ===== hdl/cfwp_ram.sv =====
module cfwp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/circular_fifo_with_peek.sv =====
// Ring-buffer FIFO with peek, capacity set by a register (1 to 16 entries).
// Input stream: one beat is one request. tuser carries the request kind
// (push, pop, peek); tdata carries the push value and the peek offset.
// Output stream: exactly one result beat per request. tuser is the success
// flag; tdata carries the popped or peeked value (zero on push or failure)
// and the occupancy after the request.
// Push, failed requests and unknown kinds answer in the cycle after
// acceptance; a successful pop or peek answers through the registered read
// of the slot memory and then the result register. One request is in flight
// at a time, so the block takes a push every cycle while the receiver keeps
// up, and takes no request during the slot read of a pop or peek.
// A capacity write empties the FIFO; write it only while no request is in
// flight. Capacity zero acts as one, above sixteen as sixteen.
// Reset empties the FIFO and sets capacity to sixteen; stored data is not
// cleared. The result register holds its beat while the receiver stalls, and
// the input accepts the next beat only when that register is free or being
// taken in the same cycle.
module circular_fifo_with_peek (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cfwp_pkg::CNT_W-1:0]          cfg_wdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [31:0] push_value, [35:32] peek_offset, [39:36] zero
  input  logic [cfwp_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // [1:0] req_type
  input  logic [cfwp_pkg::REQ_W-1:0]          s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [31:0] value, [36:32] occupancy, [39:37] zero
  output logic [cfwp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // [0] ok
  output logic                                m_axis_tuser_o
);

  import cfwp_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic              state_q, state_d;
  logic [CNT_W-1:0]  cap_q;
  logic [CNT_W-1:0]  used;
  logic [ADDR_W-1:0] head_q, head_d;
  logic [ADDR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  pend_occ_q;

  logic              out_valid_q;
  logic              out_ok_q;
  logic [DATA_W-1:0] out_value_q;
  logic [CNT_W-1:0]  out_occ_q;

  logic [REQ_W-1:0]  req;
  logic [DATA_W-1:0] push_value;
  logic [OFF_W-1:0]  peek_offset;

  logic              accept;
  logic              push_ok, pop_ok, peek_ok, rd_go;
  logic [CNT_W:0]    peek_sum;
  logic [CNT_W:0]    peek_wrap;
  logic [ADDR_W-1:0] peek_pos;
  logic [CNT_W-1:0]  head_inc, tail_inc;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;

  assign req         = s_axis_tuser_i;
  assign push_value  = s_axis_tdata_i[DATA_W-1:0];
  assign peek_offset = s_axis_tdata_i[DATA_W+OFF_W-1:DATA_W];

  always_comb begin
    if (cap_q == '0) begin
      used = CNT_W'(1);
    end else if (cap_q > CNT_W'(DEPTH)) begin
      used = CNT_W'(DEPTH);
    end else begin
      used = cap_q;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign push_ok = (req == REQ_PUSH) && (count_q < used);
  assign pop_ok  = (req == REQ_POP) && (count_q != '0);
  assign peek_ok = (req == REQ_PEEK) && ((CNT_W+1)'(peek_offset) < (CNT_W+1)'(count_q));
  assign rd_go   = accept && (pop_ok || peek_ok);

  // wrap head + offset once: both are below the capacity
  assign peek_sum  = (CNT_W+1)'(head_q) + (CNT_W+1)'(peek_offset);
  assign peek_wrap = (peek_sum >= (CNT_W+1)'(used)) ? (peek_sum - (CNT_W+1)'(used))
                                                     : peek_sum;
  assign peek_pos  = peek_wrap[ADDR_W-1:0];
  assign rd_addr   = (req == REQ_POP) ? head_q : peek_pos;

  assign head_inc = CNT_W'(head_q) + CNT_W'(1);
  assign tail_inc = CNT_W'(tail_q) + CNT_W'(1);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    state_d = state_q;
    if (cfg_we_i) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end else if (accept) begin
      if (push_ok) begin
        tail_d  = (tail_inc >= used) ? '0 : tail_inc[ADDR_W-1:0];
        count_d = count_q + CNT_W'(1);
      end else if (pop_ok) begin
        head_d  = (head_inc >= used) ? '0 : head_inc[ADDR_W-1:0];
        count_d = count_q - CNT_W'(1);
      end
    end
    case (state_q)
      ST_IDLE: begin
        if (rd_go) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  cfwp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (accept && push_ok),
    .waddr_i (tail_q),
    .wdata_i (push_value),
    .re_i    (rd_go),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CNT_W'(DEPTH);
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if ((accept && !rd_go) || (state_q == ST_READ)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_go) begin
      pend_occ_q <= count_d;
    end
    if (accept && !rd_go) begin
      out_ok_q    <= push_ok;
      out_value_q <= '0;
      out_occ_q   <= count_d;
    end else if (state_q == ST_READ) begin
      out_ok_q    <= 1'b1;
      out_value_q <= rd_data;
      out_occ_q   <= pend_occ_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_ok_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - DATA_W - CNT_W)'(0), out_occ_q, out_value_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= used)
    else $error("count exceeds capacity");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q < used) || cfg_we_i || $past(cfg_we_i))
    else $error("head outside ring");

  a_empty_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q))
    else $error("empty ring with head and tail apart");

  a_read_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !s_axis_tready_o)
    else $error("request taken during slot read");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (out_valid_q && out_ok_q))
    else $error("slot read produced no result");

endmodule

// ===== tb/tb_circular_fifo_with_peek.sv =====
`timescale 1ns / 1ps

module tb_circular_fifo_with_peek;
  import cfwp_pkg::*;

  localparam logic [REQ_W-1:0] REQ_NONE    = 2'd3;
  localparam int unsigned      CYCLE_LIMIT = 300000;
  localparam int unsigned      PHASE_ITEMS = 148;
  localparam int unsigned      HOLD_CYCLES = 80;

  typedef struct packed {
    logic             ok;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  occupancy;
  } answer_t;

  class fifo_shadow;
    logic [DATA_W-1:0] slot_q [DEPTH];
    int unsigned       head;
    int unsigned       tail;
    int unsigned       count;
    logic [CNT_W-1:0]  capacity;
    answer_t           answers [$];
    int unsigned       requests;
    int unsigned       checked;
    int unsigned       errors;

    function new();
      foreach (slot_q[i]) slot_q[i] = '0;
      head     = 0;
      tail     = 0;
      count    = 0;
      capacity = CNT_W'(DEPTH);
      requests = 0;
      checked  = 0;
      errors   = 0;
    endfunction

    function int unsigned span();
      if (capacity == 0) return 1;
      if (capacity > DEPTH) return DEPTH;
      return capacity;
    endfunction

    function int unsigned step_ptr(int unsigned idx);
      return (idx + 1 >= span()) ? 0 : idx + 1;
    endfunction

    function void write_capacity(logic [CNT_W-1:0] v);
      capacity = v;
      head     = 0;
      tail     = 0;
      count    = 0;
    endfunction

    function void take_request(logic [REQ_W-1:0] req, logic [DATA_W-1:0] val,
                               logic [OFF_W-1:0] off);
      answer_t     a;
      int unsigned pos;
      a = '0;
      case (req)
        REQ_PUSH: begin
          if (count < span()) begin
            slot_q[tail] = val;
            tail = step_ptr(tail);
            count++;
            a.ok = 1'b1;
          end
        end
        REQ_POP: begin
          if (count != 0) begin
            a.value = slot_q[head];
            head = step_ptr(head);
            count--;
            a.ok = 1'b1;
          end
        end
        REQ_PEEK: begin
          if (off < count) begin
            pos = head + off;
            while (pos >= span()) pos -= span();
            a.value = slot_q[pos];
            a.ok = 1'b1;
          end
        end
        default: ;
      endcase
      a.occupancy = CNT_W'(count);
      answers.push_back(a);
      requests++;
    endfunction

    function void compare_result(logic ok, logic [DATA_W-1:0] value,
                                 logic [CNT_W-1:0] occupancy);
      answer_t want;
      if (answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual ok=%0b value=%h occ=%0d",
                 $time, ok, value, occupancy);
        return;
      end
      want = answers.pop_front();
      checked++;
      if (ok !== want.ok) begin
        errors++;
        $display("%0t: ok mismatch, expected %0b actual %0b", $time, want.ok, ok);
      end
      if (value !== want.value) begin
        errors++;
        $display("%0t: value mismatch, expected %h actual %h", $time, want.value, value);
      end
      if (occupancy !== want.occupancy) begin
        errors++;
        $display("%0t: occupancy mismatch, expected %0d actual %0d",
                 $time, want.occupancy, occupancy);
      end
    endfunction
  endclass

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   cfg_we          = 1'b0;
  logic [CNT_W-1:0]       cfg_wdata       = '0;
  logic                   s_valid         = 1'b0;
  logic                   s_ready;
  logic [IN_TDATA_W-1:0]  s_tdata         = '0;
  logic [REQ_W-1:0]       s_tuser         = '0;
  logic                   m_valid;
  logic                   m_ready         = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;

  fifo_shadow  shadow          = new();
  bit          no_gaps         = 1'b0;
  int unsigned hold_off_cycles = 0;
  int unsigned settings_seen   = 0;
  int unsigned cycle_count     = 0;

  circular_fifo_with_peek u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 5);
  endfunction

  task automatic send(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] val,
                      input logic [OFF_W-1:0] off);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tuser <= req;
    s_tdata <= {4'b0, off, val};
    s_valid <= 1'b1;
    do @(posedge clk_i); while (!s_ready);
    shadow.take_request(req, val, off);
  endtask

  task automatic set_capacity(input logic [CNT_W-1:0] v);
    s_valid <= 1'b0;
    while (shadow.answers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    shadow.write_capacity(v);
    settings_seen++;
    cfg_we <= 1'b0;
  endtask

  task automatic run_mix(input int unsigned n_items);
    int unsigned      left;
    int unsigned      seg;
    int unsigned      push_pct;
    logic [REQ_W-1:0] req;
    logic [DATA_W-1:0] val;
    logic [OFF_W-1:0] off;
    left = n_items;
    while (left > 0) begin
      seg = $urandom_range(8, 40);
      case ($urandom_range(0, 2))
        0:       push_pct = 15;
        1:       push_pct = 50;
        default: push_pct = 85;
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < seg && left > 0; i++) begin
        if ($urandom_range(0, 39) == 0) req = REQ_NONE;
        else if ($urandom_range(0, 99) < push_pct) req = REQ_PUSH;
        else if ($urandom_range(0, 1) == 0) req = REQ_POP;
        else req = REQ_PEEK;
        case ($urandom_range(0, 9))
          0:       val = '0;
          1:       val = '1;
          default: val = $urandom;
        endcase
        if (shadow.count != 0 && $urandom_range(0, 6) != 0)
          off = OFF_W'($urandom_range(0, shadow.count - 1));
        else
          off = OFF_W'($urandom_range(0, 15));
        send(req, val, off);
        left--;
      end
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    forever begin
      if (hold_off_cycles != 0) begin
        m_ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end
      stall = draw_gap();
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!(m_valid && m_ready));
      shadow.compare_result(m_tuser, m_tdata[DATA_W-1:0], m_tdata[DATA_W+CNT_W-1:DATA_W]);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: run exceeded %0d cycles, %0d results still pending",
             $time, CYCLE_LIMIT, shadow.answers.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_caps [9];
    phase_caps = '{0, 1, 31, 16, 17, 3, $urandom_range(2, 15), $urandom_range(0, 31), 8};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(REQ_POP,  '0, '0);
    send(REQ_PEEK, '0, '0);
    send(REQ_NONE, 32'hDEAD_BEEF, 4'hF);
    send(REQ_PUSH, 32'hFFFF_FFFF, '0);
    send(REQ_PUSH, '0, 4'hF);
    send(REQ_PUSH, 32'h5A5A_5A5A, '0);
    send(REQ_PEEK, $urandom, 4'd0);
    send(REQ_PEEK, '0, 4'd2);
    send(REQ_PEEK, '0, 4'd3);
    send(REQ_PEEK, '1, 4'd15);
    send(REQ_NONE, '0, '0);
    send(REQ_POP,  '0, '0);
    send(REQ_POP,  '0, '0);

    // one entry left; the capacity write must drop it
    set_capacity(2);
    send(REQ_POP,  '0, '0);
    send(REQ_PUSH, $urandom, '0);
    send(REQ_PUSH, $urandom, '0);
    send(REQ_PUSH, $urandom, '0);
    send(REQ_PEEK, '0, 4'd1);
    send(REQ_POP,  '0, '0);
    send(REQ_PUSH, $urandom, '0);
    send(REQ_PEEK, '0, 4'd1);
    send(REQ_POP,  '0, '0);
    send(REQ_POP,  '0, '0);
    send(REQ_POP,  '0, '0);

    for (int p = 0; p < 9; p++) begin
      set_capacity(CNT_W'(phase_caps[p]));
      // stall the result side long enough to back up the request side
      if (phase_caps[p] == DEPTH) hold_off_cycles = HOLD_CYCLES;
      run_mix(PHASE_ITEMS);
    end
    s_valid <= 1'b0;

    while (shadow.answers.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d requests (push, pop, peek, unknown) over %0d capacity settings,",
             shadow.requests, settings_seen + 1);
    $display("%0d result beats compared, %0d field errors.", shadow.checked, shadow.errors);
    if (shadow.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/cfwp_pkg.sv
hdl/cfwp_ram.sv
hdl/circular_fifo_with_peek.sv
tb/tb_circular_fifo_with_peek.sv
